### rtl/core/tlge_pkg.sv
// shared types, codes and constants of the toroidal life generation engine
package tlge_pkg;

  localparam int MAX_COLS_DEF = 128;
  localparam int MAX_ROWS_DEF = 64;

  // active sizes and coordinates travel in this width (parameters stay below 256)
  localparam int DIM_W   = 8;
  localparam int LIVE_W  = 14;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;

  localparam logic [LIVE_W-1:0] LIVE_SAT   = 14'h3fff;
  localparam logic [DIM_W-1:0]  DIM_MIN    = 8'd3;
  localparam logic [7:0]        RST_WIDTH  = 8'd128;
  localparam logic [6:0]        RST_HEIGHT = 7'd64;

  // rule b3/s23
  localparam logic [3:0] BIRTH_N   = 4'd3;
  localparam logic [3:0] SURVIVE_N = 4'd2;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_STEP  = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;
  localparam logic [1:0] ACT_CLEAR = 2'd3;

  typedef struct packed {
    logic [1:0] action;
    logic [6:0] col;
    logic [5:0] row;
    logic       cell_value;
  } in_item_t;

  typedef struct packed {
    logic              cell_alive;
    logic [3:0]        neighbour_count;
    logic [LIVE_W-1:0] live_total;
  } out_item_t;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } geom_t;

endpackage

### rtl/core/toroidal_life_generation_engine.sv
// toroidal game of life engine (b3/s23): top level with the request sequencer
//
// A request is taken on start while busy is low and carries one action: write a
// cell, step one generation, read a cell or clear the grid. Exactly one result
// comes back on out_result, marked by out_strobe for a single cycle; the
// receiver cannot hold it off, and busy stays high until the strobe cycle
// (a clear never raises it). Every result carries the live-cell count of the
// active area after the action. Steps of each action, with h active rows:
//   clear: row valid bits drop at once
//   read:  one sweep of the grid memory to count cells
//   write: read-modify-write of the row, then the same sweep
//   step:  h + 1 row reads, new rows written back as they form
// The grid memory has one read port and one write port, one row per cycle each.
// Reset marks every row dead and sets the size registers to 128 by 64; no
// clearing pass is needed. The user must write the size registers over the
// cfg_ port only while no request is in flight; the block does not enforce it.
module toroidal_life_generation_engine #(
  parameter int MAX_COLS = tlge_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = tlge_pkg::MAX_ROWS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  tlge_pkg::in_item_t          in_item,
  output logic                        out_strobe,
  output tlge_pkg::out_item_t         out_result,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [tlge_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [tlge_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [tlge_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);
  import tlge_pkg::*;

  localparam int RA_W  = $clog2(MAX_ROWS);
  localparam int CA_W  = $clog2(MAX_COLS);
  localparam int CNT_W = $clog2(MAX_ROWS * MAX_COLS + 1);
  localparam int SUM_W = (CNT_W > LIVE_W) ? CNT_W : LIVE_W;
  localparam int FC_W  = DIM_W + 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_WR_RD  = 3'd1;
  localparam logic [2:0] S_WR_MOD = 3'd2;
  localparam logic [2:0] S_CNT    = 3'd3;
  localparam logic [2:0] S_STEP   = 3'd4;
  localparam logic [2:0] S_DRAIN  = 3'd5;

  geom_t            geom;
  logic [DIM_W-1:0] act_w, act_h;
  logic [DIM_W-1:0] col_ext, row_ext, x_sat, y_sat, up_sat, dn_sat;
  logic             accept;

  logic [2:0]       state_r, state_nxt;
  logic [1:0]       act_r;
  logic [DIM_W-1:0] x_r, y_r, up_r, dn_r;
  logic             val_r;
  logic [DIM_W-1:0] idx_r, idx_nxt;
  logic [FC_W-1:0]  feed_cnt_r;
  logic             arr_vld_r, arr_sweep_r;
  logic [DIM_W-1:0] arr_row_r;
  logic [MAX_COLS-1:0] row_a_r, row_b_r, row_c_r;
  logic [MAX_COLS-1:0] nrow_r;
  logic             nrow_vld_r;
  logic [DIM_W-1:0] nrow_addr_r;
  logic             out_strobe_r, out_strobe_nxt;
  out_item_t        out_result_r, out_result_nxt;

  logic                mem_clr, mem_rd_en, mem_wr_en;
  logic [DIM_W-1:0]    mem_rd_row, mem_wr_row;
  logic [MAX_COLS-1:0] mem_rd_data, mem_wr_data, patched;

  logic                step_mode, inject, feed_vld, done;
  logic [MAX_COLS-1:0] feed_row, rule_next, rule_new;
  logic [3:0]          sel_count;
  logic                pc_vld, pc_busy;
  logic [MAX_COLS-1:0] pc_row;
  logic [CNT_W-1:0]    live_acc;
  logic [SUM_W-1:0]    live_ext;
  logic [LIVE_W-1:0]   live_sat;
  logic [CA_W-1:0]     x_idx;

  tlge_cfg_regs #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .geom       (geom)
  );

  assign act_w = geom.width;
  assign act_h = geom.height;

  // coordinates saturate to the last active column and row
  assign col_ext = DIM_W'(in_item.col);
  assign row_ext = DIM_W'(in_item.row);
  assign x_sat   = (col_ext > act_w - DIM_W'(1)) ? act_w - DIM_W'(1) : col_ext;
  assign y_sat   = (row_ext > act_h - DIM_W'(1)) ? act_h - DIM_W'(1) : row_ext;
  assign up_sat  = (y_sat == '0) ? act_h - DIM_W'(1) : y_sat - DIM_W'(1);
  assign dn_sat  = (y_sat + DIM_W'(1) >= act_h) ? '0 : y_sat + DIM_W'(1);

  assign busy      = (state_r != S_IDLE);
  assign accept    = start & ~busy;
  assign step_mode = (act_r == ACT_STEP);
  assign x_idx     = x_r[CA_W-1:0];

  // step window: row_a = row above, row_b = current row, row_c = old row 0
  assign inject   = step_mode && (state_r == S_DRAIN) && !arr_vld_r
                    && (feed_cnt_r == FC_W'(act_h) + FC_W'(1));
  assign feed_vld = (step_mode && arr_vld_r) || inject;
  assign feed_row = arr_vld_r ? mem_rd_data : row_c_r;
  assign rule_next = step_mode ? feed_row : row_c_r;

  tlge_grid_mem #(.NCOLS(MAX_COLS), .NROWS(MAX_ROWS)) u_mem (
    .clk    (clk),
    .rst_n  (rst_n),
    .clr    (mem_clr),
    .rd_en  (mem_rd_en),
    .rd_addr(mem_rd_row[RA_W-1:0]),
    .rd_data(mem_rd_data),
    .wr_en  (mem_wr_en),
    .wr_addr(mem_wr_row[RA_W-1:0]),
    .wr_data(mem_wr_data)
  );

  tlge_row_rule #(.NCOLS(MAX_COLS)) u_rule (
    .prev_row (row_a_r),
    .cur_row  (row_b_r),
    .next_row (rule_next),
    .act_width(act_w),
    .sel_col  (x_r),
    .new_row  (rule_new),
    .sel_count(sel_count)
  );

  assign pc_vld = step_mode ? nrow_vld_r : arr_sweep_r;
  assign pc_row = step_mode ? nrow_r : mem_rd_data;

  tlge_live_count #(.NCOLS(MAX_COLS), .CNT_W(CNT_W)) u_count (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr      (accept),
    .in_vld   (pc_vld),
    .in_row   (pc_row),
    .act_width(act_w),
    .busy     (pc_busy),
    .total    (live_acc)
  );

  assign live_ext = SUM_W'(live_acc);
  assign live_sat = (live_ext > SUM_W'(LIVE_SAT)) ? LIVE_SAT : live_ext[LIVE_W-1:0];

  assign done = !arr_vld_r && !nrow_vld_r && !pc_busy
                && (!step_mode || (feed_cnt_r == FC_W'(act_h) + FC_W'(2)));

  always_comb begin
    patched        = mem_rd_data;
    patched[x_idx] = val_r;
  end

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    out_strobe_nxt = 1'b0;
    out_result_nxt = out_result_r;
    mem_clr        = 1'b0;
    mem_rd_en      = 1'b0;
    mem_rd_row     = idx_r;
    mem_wr_en      = 1'b0;
    mem_wr_row     = nrow_addr_r;
    mem_wr_data    = nrow_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          idx_nxt = '0;
          case (in_item.action)
            ACT_WRITE: state_nxt = S_WR_RD;
            ACT_STEP:  state_nxt = S_STEP;
            ACT_READ:  state_nxt = S_CNT;
            ACT_CLEAR: begin
              mem_clr        = 1'b1;
              out_strobe_nxt = 1'b1;
              out_result_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      S_WR_RD: begin
        mem_rd_en  = 1'b1;
        mem_rd_row = y_r;
        state_nxt  = S_WR_MOD;
      end
      S_WR_MOD: begin
        mem_wr_en   = 1'b1;
        mem_wr_row  = y_r;
        mem_wr_data = patched;
        state_nxt   = S_CNT;
      end
      S_CNT: begin
        mem_rd_en = 1'b1;
        idx_nxt   = idx_r + DIM_W'(1);
        if (idx_r == act_h - DIM_W'(1)) state_nxt = S_DRAIN;
      end
      S_STEP: begin
        // old last row first, then rows 0 to h-1
        mem_rd_en  = 1'b1;
        mem_rd_row = (idx_r == '0) ? act_h - DIM_W'(1) : idx_r - DIM_W'(1);
        idx_nxt    = idx_r + DIM_W'(1);
        if (idx_r == act_h) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (done) begin
          out_strobe_nxt                 = 1'b1;
          out_result_nxt.cell_alive      = step_mode ? 1'b0 : row_b_r[x_idx];
          out_result_nxt.neighbour_count = step_mode ? 4'd0 : sel_count;
          out_result_nxt.live_total      = live_sat;
          state_nxt                      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // new rows of a step go back as they form
    if (nrow_vld_r) begin
      mem_wr_en   = 1'b1;
      mem_wr_row  = nrow_addr_r;
      mem_wr_data = nrow_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      idx_r        <= '0;
      feed_cnt_r   <= '0;
      arr_vld_r    <= 1'b0;
      arr_sweep_r  <= 1'b0;
      nrow_vld_r   <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      arr_vld_r    <= mem_rd_en;
      arr_sweep_r  <= mem_rd_en && (state_r == S_CNT);
      nrow_vld_r   <= feed_vld && (feed_cnt_r >= FC_W'(2));
      out_strobe_r <= out_strobe_nxt;
      if (accept) feed_cnt_r <= '0;
      else if (feed_vld) feed_cnt_r <= feed_cnt_r + FC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    out_result_r <= out_result_nxt;
    arr_row_r    <= mem_rd_row;
    if (accept) begin
      act_r <= in_item.action;
      x_r   <= x_sat;
      y_r   <= y_sat;
      up_r  <= up_sat;
      dn_r  <= dn_sat;
      val_r <= in_item.cell_value;
    end
    // sweep for read and write keeps the three rows around the addressed cell
    if (!step_mode && arr_sweep_r) begin
      if (arr_row_r == up_r) row_a_r <= mem_rd_data;
      if (arr_row_r == y_r)  row_b_r <= mem_rd_data;
      if (arr_row_r == dn_r) row_c_r <= mem_rd_data;
    end
    if (feed_vld) begin
      row_a_r <= row_b_r;
      row_b_r <= feed_row;
      if (feed_cnt_r == FC_W'(1)) row_c_r <= feed_row;
      nrow_r      <= rule_new;
      nrow_addr_r <= DIM_W'(feed_cnt_r - FC_W'(2));
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_result = out_result_r;

endmodule

### rtl/core/tlge_cfg_regs.sv
// register port holding grid width and height, with the clamped active size
module tlge_cfg_regs #(
  parameter int MAX_COLS = tlge_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = tlge_pkg::MAX_ROWS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [tlge_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [tlge_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [tlge_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                         cfg_pready,
  output tlge_pkg::geom_t              geom
);
  import tlge_pkg::*;

  localparam logic [DIM_W-1:0] W_MAX = DIM_W'(MAX_COLS);
  localparam logic [DIM_W-1:0] H_MAX = DIM_W'(MAX_ROWS);

  logic [7:0]       grid_width_r;
  logic [6:0]       grid_height_r;
  logic             reg_sel;
  logic             wr_hit;
  logic [DIM_W-1:0] height_ext;

  assign cfg_pready = 1'b1;
  assign reg_sel    = cfg_paddr[CFG_AW-1];
  assign wr_hit     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= RST_WIDTH;
      grid_height_r <= RST_HEIGHT;
    end else if (wr_hit) begin
      case (reg_sel)
        REG_WIDTH:  grid_width_r  <= cfg_pwdata[7:0];
        REG_HEIGHT: grid_height_r <= cfg_pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_WIDTH:  cfg_prdata = CFG_DW'(grid_width_r);
      REG_HEIGHT: cfg_prdata = CFG_DW'(grid_height_r);
      default:    cfg_prdata = '0;
    endcase
  end

  assign height_ext = DIM_W'(grid_height_r);

  always_comb begin
    if (grid_width_r < DIM_MIN)    geom.width = DIM_MIN;
    else if (grid_width_r > W_MAX) geom.width = W_MAX;
    else                           geom.width = grid_width_r;
    if (height_ext < DIM_MIN)      geom.height = DIM_MIN;
    else if (height_ext > H_MAX)   geom.height = H_MAX;
    else                           geom.height = height_ext;
  end

endmodule

### rtl/core/tlge_grid_mem.sv
// cell grid memory, one row per entry, with per-row valid bits for reset and clear
module tlge_grid_mem #(
  parameter int NCOLS = tlge_pkg::MAX_COLS_DEF,
  parameter int NROWS = tlge_pkg::MAX_ROWS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     clr,
  input  logic                     rd_en,
  input  logic [$clog2(NROWS)-1:0] rd_addr,
  output logic [NCOLS-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(NROWS)-1:0] wr_addr,
  input  logic [NCOLS-1:0]         wr_data
);
  import tlge_pkg::*;

  logic [NCOLS-1:0] mem [NROWS];
  logic [NROWS-1:0] row_vld_r;
  logic [NCOLS-1:0] rd_q_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q_r <= mem[rd_addr];
  end

  // a row never written since reset or clear reads as all dead
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (clr) row_vld_r <= '0;
      else if (wr_en) row_vld_r[wr_addr] <= 1'b1;
      if (rd_en) rd_vld_r <= row_vld_r[rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

### rtl/core/tlge_row_rule.sv
// neighbour counts and next state of one row from the rows above and below
module tlge_row_rule #(
  parameter int NCOLS = tlge_pkg::MAX_COLS_DEF
) (
  input  logic [NCOLS-1:0]           prev_row,
  input  logic [NCOLS-1:0]           cur_row,
  input  logic [NCOLS-1:0]           next_row,
  input  logic [tlge_pkg::DIM_W-1:0] act_width,
  input  logic [tlge_pkg::DIM_W-1:0] sel_col,
  output logic [NCOLS-1:0]           new_row,
  output logic [3:0]                 sel_count
);
  import tlge_pkg::*;

  localparam int CA_W = $clog2(NCOLS);

  logic [CA_W-1:0]  wrap_idx;
  logic [NCOLS-1:0] pl, pr, cl, cr, nl, nr;
  logic [3:0]       cnt [NCOLS];

  // bit x holds the cell at x-1; column 0 sees the last active column
  function automatic logic [NCOLS-1:0] to_left(input logic [NCOLS-1:0] r,
                                               input logic [CA_W-1:0]  wi);
    return {r[NCOLS-2:0], r[wi]};
  endfunction

  // bit x holds the cell at x+1; the last active column sees column 0
  function automatic logic [NCOLS-1:0] to_right(input logic [NCOLS-1:0] r,
                                                input logic [CA_W-1:0]  wi);
    logic [NCOLS-1:0] v;
    v     = {1'b0, r[NCOLS-1:1]};
    v[wi] = r[0];
    return v;
  endfunction

  assign wrap_idx = CA_W'(act_width - DIM_W'(1));

  assign pl = to_left(prev_row, wrap_idx);
  assign pr = to_right(prev_row, wrap_idx);
  assign cl = to_left(cur_row, wrap_idx);
  assign cr = to_right(cur_row, wrap_idx);
  assign nl = to_left(next_row, wrap_idx);
  assign nr = to_right(next_row, wrap_idx);

  always_comb begin
    for (int x = 0; x < NCOLS; x++) begin
      cnt[x] = 4'(pl[x]) + 4'(prev_row[x]) + 4'(pr[x]) + 4'(cl[x]) + 4'(cr[x])
             + 4'(nl[x]) + 4'(next_row[x]) + 4'(nr[x]);
      if (DIM_W'(x) < act_width)
        new_row[x] = (cnt[x] == BIRTH_N) | (cur_row[x] & (cnt[x] == SURVIVE_N));
      else
        new_row[x] = cur_row[x];
    end
  end

  assign sel_count = cnt[sel_col[CA_W-1:0]];

endmodule

### rtl/core/tlge_live_count.sv
// pipelined population count of rows inside the active width, accumulated per request
module tlge_live_count #(
  parameter int NCOLS = tlge_pkg::MAX_COLS_DEF,
  parameter int CNT_W = tlge_pkg::LIVE_W
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       clr,
  input  logic                       in_vld,
  input  logic [NCOLS-1:0]           in_row,
  input  logic [tlge_pkg::DIM_W-1:0] act_width,
  output logic                       busy,
  output logic [CNT_W-1:0]           total
);
  import tlge_pkg::*;

  localparam int NCHUNK = (NCOLS + 7) / 8;
  localparam int NGRP   = (NCHUNK + 7) / 8;
  localparam int NCH    = NGRP * 8;
  localparam int PADW   = NCH * 8;

  logic [PADW-1:0]  pad;
  logic [3:0]       chunk_nxt [NCH];
  logic [3:0]       chunk_r   [NCH];
  logic [6:0]       grp_nxt   [NGRP];
  logic [6:0]       grp_r     [NGRP];
  logic             s1_vld_r, s2_vld_r;
  logic [CNT_W-1:0] acc_r, acc_nxt;

  always_comb begin
    pad = '0;
    for (int i = 0; i < NCOLS; i++) pad[i] = in_row[i] & (DIM_W'(i) < act_width);
    for (int c = 0; c < NCH; c++) begin
      chunk_nxt[c] = '0;
      for (int j = 0; j < 8; j++) chunk_nxt[c] = chunk_nxt[c] + 4'(pad[c*8+j]);
    end
  end

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int j = 0; j < 8; j++) grp_nxt[g] = grp_nxt[g] + 7'(chunk_r[g*8+j]);
    end
  end

  always_comb begin
    acc_nxt = acc_r;
    for (int g = 0; g < NGRP; g++) acc_nxt = acc_nxt + CNT_W'(grp_r[g]);
  end

  always_ff @(posedge clk) begin
    if (in_vld) chunk_r <= chunk_nxt;
    if (s1_vld_r) grp_r <= grp_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      acc_r    <= '0;
    end else begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
      if (clr) acc_r <= '0;
      else if (s2_vld_r) acc_r <= acc_nxt;
    end
  end

  assign busy  = s1_vld_r | s2_vld_r;
  assign total = acc_r;

endmodule
